FILE: src/sit_pkg.sv
// Shared constants and types for the segment intersection test.
`timescale 1ns / 1ps

package sit_pkg;

    // Result coordinate width (signed fixed point)
    localparam int OUT_W          = 24;
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    // Sideband that rides along with each item through the divider
    typedef struct packed {
        logic                    hit;
        logic                    neg_x;
        logic                    neg_y;
        logic signed [OUT_W-1:0] p0x;
        logic signed [OUT_W-1:0] p0y;
    } sit_side_t;

endpackage

FILE: src/segment_intersection_test.sv
// Segment intersection test: top level with pipeline, result register and skid.
`timescale 1ns / 1ps
//
// Usage
//   The s_ channel takes one segment pair per item: segment A from
//   (a_start_x, a_start_y) to (a_end_x, a_end_y), segment B likewise. The m_
//   channel returns one result per item, in order: m_hit, and on a hit the
//   crossing point A start + t * (A end - A start) in signed fixed point with
//   FRAC_BITS fraction bits, floored; without a hit both coordinates are zero.
//   Parallel and collinear pairs (zero cross denominator) never hit.
//   Throughput: one item per cycle, sustained, as long as m_ready stays high.
//   Pipeline: four front-end stages (differences, products, sums and sign
//   fix, hit test and dividend), one divider stage per quotient bit, and
//   the result register lie between acceptance and m_valid.
//   Stall: when m_ready is low the result register holds; one more item moves
//   into a skid register, after which the whole pipeline freezes and s_ready
//   drops until the receiver takes the held result. Nothing is lost or repeated.
//   Reset (aresetn low, synchronous) empties the pipeline; no other state.
//
module segment_intersection_test #(
    parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sit_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [COORD_BITS-1:0]         s_a_start_x,
    input  logic signed [COORD_BITS-1:0]         s_a_start_y,
    input  logic signed [COORD_BITS-1:0]         s_a_end_x,
    input  logic signed [COORD_BITS-1:0]         s_a_end_y,
    input  logic signed [COORD_BITS-1:0]         s_b_start_x,
    input  logic signed [COORD_BITS-1:0]         s_b_start_y,
    input  logic signed [COORD_BITS-1:0]         s_b_end_x,
    input  logic signed [COORD_BITS-1:0]         s_b_end_y,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_hit,
    output logic signed [sit_pkg::OUT_W-1:0]     m_cross_x,
    output logic signed [sit_pkg::OUT_W-1:0]     m_cross_y
);
    import sit_pkg::*;

    // numerator/denominator width and quotient bits
    localparam int NW = 2 * (COORD_BITS + 1) + 1;
    localparam int QB = COORD_BITS + 1 + FRAC_BITS;

    logic          en;
    logic          g_valid, d_valid;
    sit_side_t     g_side, d_side;
    logic [NW-1:0] g_den, g_rem_x, g_rem_y, d_rem_x, d_rem_y;
    logic [QB-1:0] g_lo_x, g_lo_y, d_quo_x, d_quo_y;

    logic                    m_valid_reg, skid_vld_reg;
    logic                    hit_reg, skid_hit_reg;
    logic signed [OUT_W-1:0] x_reg, y_reg, skid_x_reg, skid_y_reg;

    logic                    res_hit;
    logic signed [OUT_W-1:0] res_x, res_y;
    logic [OUT_W-1:0]        q_x, q_y, val_x, val_y;

    // Pipeline advances unless the skid register is occupied
    assign en      = !skid_vld_reg;
    assign s_ready = en;

    sit_geom #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .NW         (NW),
        .QB         (QB)
    ) u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .a_start_x (s_a_start_x),
        .a_start_y (s_a_start_y),
        .a_end_x   (s_a_end_x),
        .a_end_y   (s_a_end_y),
        .b_start_x (s_b_start_x),
        .b_start_y (s_b_start_y),
        .b_end_x   (s_b_end_x),
        .b_end_y   (s_b_end_y),
        .out_valid (g_valid),
        .out_side  (g_side),
        .out_den   (g_den),
        .out_rem_x (g_rem_x),
        .out_lo_x  (g_lo_x),
        .out_rem_y (g_rem_y),
        .out_lo_y  (g_lo_y)
    );

    sit_div #(
        .NW (NW),
        .QB (QB)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (g_valid),
        .in_side   (g_side),
        .in_den    (g_den),
        .in_rem_x  (g_rem_x),
        .in_lo_x   (g_lo_x),
        .in_rem_y  (g_rem_y),
        .in_lo_y   (g_lo_y),
        .out_valid (d_valid),
        .out_side  (d_side),
        .out_rem_x (d_rem_x),
        .out_quo_x (d_quo_x),
        .out_rem_y (d_rem_y),
        .out_quo_y (d_quo_y)
    );

    // Floor the signed quotient: a negative step with a remainder drops by one,
    // then add the start point on the fraction grid. Wrap to the output width.
    always_comb begin
        q_x     = OUT_W'(d_quo_x);
        q_y     = OUT_W'(d_quo_y);
        val_x   = d_side.neg_x ? ~q_x + OUT_W'(d_rem_x == '0) : q_x;
        val_y   = d_side.neg_y ? ~q_y + OUT_W'(d_rem_y == '0) : q_y;
        res_hit = d_side.hit;
        res_x   = res_hit ? (d_side.p0x <<< FRAC_BITS) + signed'(val_x) : '0;
        res_y   = res_hit ? (d_side.p0y <<< FRAC_BITS) + signed'(val_y) : '0;
    end

    // Result register with a one-item skid behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            if (skid_vld_reg) begin
                m_valid_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                m_valid_reg <= d_valid;
            end
        end else if (en && d_valid) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            if (skid_vld_reg) begin
                hit_reg <= skid_hit_reg;
                x_reg   <= skid_x_reg;
                y_reg   <= skid_y_reg;
            end else begin
                hit_reg <= res_hit;
                x_reg   <= res_x;
                y_reg   <= res_y;
            end
        end else if (en && d_valid) begin
            skid_hit_reg <= res_hit;
            skid_x_reg   <= res_x;
            skid_y_reg   <= res_y;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_hit     = hit_reg;
    assign m_cross_x = x_reg;
    assign m_cross_y = y_reg;

`ifndef SYNTHESIS
    // The skid register is only used behind a held result
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> m_valid_reg)
        else $error("skid occupied with empty result register");

    // The skid fills only when the previous result was stalled
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_vld_reg) |-> $past(m_valid_reg && !m_ready))
        else $error("skid filled without a stall");

    // A miss always reports the origin
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_hit) |-> (m_cross_x == '0 && m_cross_y == '0))
        else $error("nonzero crossing point on a miss");
`endif

endmodule

FILE: src/sit_geom.sv
// Front end: differences, cross products, sign normalization, hit test, dividend.
`timescale 1ns / 1ps

module sit_geom #(
    parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sit_pkg::FRAC_BITS_DEF,
    parameter int NW         = 2 * (COORD_BITS + 1) + 1,
    parameter int QB         = COORD_BITS + 1 + FRAC_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [COORD_BITS-1:0]  a_start_x,
    input  logic signed [COORD_BITS-1:0]  a_start_y,
    input  logic signed [COORD_BITS-1:0]  a_end_x,
    input  logic signed [COORD_BITS-1:0]  a_end_y,
    input  logic signed [COORD_BITS-1:0]  b_start_x,
    input  logic signed [COORD_BITS-1:0]  b_start_y,
    input  logic signed [COORD_BITS-1:0]  b_end_x,
    input  logic signed [COORD_BITS-1:0]  b_end_y,
    output logic                          out_valid,
    output sit_pkg::sit_side_t            out_side,
    output logic [NW-1:0]                 out_den,
    output logic [NW-1:0]                 out_rem_x,
    output logic [QB-1:0]                 out_lo_x,
    output logic [NW-1:0]                 out_rem_y,
    output logic [QB-1:0]                 out_lo_y
);
    import sit_pkg::*;

    localparam int CW = COORD_BITS + 1;
    localparam int PW = 2 * CW;
    localparam int MW = CW + NW;

    logic [3:0] vld_reg;

    // stage 1
    logic signed [CW-1:0]         s1x_reg, s1y_reg, s2x_reg, s2y_reg, dx_reg, dy_reg;
    logic signed [COORD_BITS-1:0] p0x1_reg, p0y1_reg;
    // stage 2
    logic signed [PW-1:0]         sdy_reg, sdx_reg, tdy_reg, tdx_reg, d1_reg, d2_reg;
    logic signed [CW-1:0]         s1x2_reg, s1y2_reg;
    logic signed [COORD_BITS-1:0] p0x2_reg, p0y2_reg;
    // stage 3
    logic signed [NW-1:0]         snum_reg, tnum_reg, den_reg;
    logic signed [CW-1:0]         s1x3_reg, s1y3_reg;
    logic signed [COORD_BITS-1:0] p0x3_reg, p0y3_reg;
    // stage 4
    sit_side_t                    side_reg;
    logic [NW-1:0]                den4_reg, rem_x_reg, rem_y_reg;
    logic [QB-1:0]                lo_x_reg, lo_y_reg;

    logic signed [NW-1:0] snum_raw, tnum_raw, den_raw;
    logic                 den_neg;
    logic [CW-1:0]        mag_x, mag_y;
    logic [MW-1:0]        prod_x, prod_y;
    logic                 hit;

    always_comb begin
        snum_raw = NW'(sdy_reg) - NW'(sdx_reg);
        tnum_raw = NW'(tdy_reg) - NW'(tdx_reg);
        den_raw  = NW'(d1_reg) - NW'(d2_reg);
        den_neg  = den_raw[NW-1];
    end

    always_comb begin
        hit = (den_reg != '0) && !snum_reg[NW-1] && (snum_reg <= den_reg)
              && !tnum_reg[NW-1] && (tnum_reg <= den_reg);
        mag_x  = s1x3_reg[CW-1] ? CW'(-s1x3_reg) : CW'(s1x3_reg);
        mag_y  = s1y3_reg[CW-1] ? CW'(-s1y3_reg) : CW'(s1y3_reg);
        prod_x = MW'(mag_x) * MW'(tnum_reg[NW-1:0]);
        prod_y = MW'(mag_y) * MW'(tnum_reg[NW-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1x_reg  <= CW'(a_end_x) - CW'(a_start_x);
            s1y_reg  <= CW'(a_end_y) - CW'(a_start_y);
            s2x_reg  <= CW'(b_end_x) - CW'(b_start_x);
            s2y_reg  <= CW'(b_end_y) - CW'(b_start_y);
            dx_reg   <= CW'(a_start_x) - CW'(b_start_x);
            dy_reg   <= CW'(a_start_y) - CW'(b_start_y);
            p0x1_reg <= a_start_x;
            p0y1_reg <= a_start_y;

            sdy_reg  <= PW'(s1x_reg) * PW'(dy_reg);
            sdx_reg  <= PW'(s1y_reg) * PW'(dx_reg);
            tdy_reg  <= PW'(s2x_reg) * PW'(dy_reg);
            tdx_reg  <= PW'(s2y_reg) * PW'(dx_reg);
            d1_reg   <= PW'(s1x_reg) * PW'(s2y_reg);
            d2_reg   <= PW'(s2x_reg) * PW'(s1y_reg);
            s1x2_reg <= s1x_reg;
            s1y2_reg <= s1y_reg;
            p0x2_reg <= p0x1_reg;
            p0y2_reg <= p0y1_reg;

            // make the denominator nonnegative
            snum_reg <= den_neg ? -snum_raw : snum_raw;
            tnum_reg <= den_neg ? -tnum_raw : tnum_raw;
            den_reg  <= den_neg ? -den_raw : den_raw;
            s1x3_reg <= s1x2_reg;
            s1y3_reg <= s1y2_reg;
            p0x3_reg <= p0x2_reg;
            p0y3_reg <= p0y2_reg;

            side_reg.hit   <= hit;
            side_reg.neg_x <= s1x3_reg[CW-1];
            side_reg.neg_y <= s1y3_reg[CW-1];
            side_reg.p0x   <= OUT_W'(p0x3_reg);
            side_reg.p0y   <= OUT_W'(p0y3_reg);
            den4_reg       <= den_reg[NW-1:0];
            // dividend = prod << FRAC_BITS; high part seeds the remainder
            rem_x_reg      <= prod_x[MW-1:CW];
            rem_y_reg      <= prod_y[MW-1:CW];
            lo_x_reg       <= QB'(prod_x[CW-1:0]) << FRAC_BITS;
            lo_y_reg       <= QB'(prod_y[CW-1:0]) << FRAC_BITS;
        end
    end

    assign out_valid = vld_reg[3];
    assign out_side  = side_reg;
    assign out_den   = den4_reg;
    assign out_rem_x = rem_x_reg;
    assign out_lo_x  = lo_x_reg;
    assign out_rem_y = rem_y_reg;
    assign out_lo_y  = lo_y_reg;

endmodule

FILE: src/sit_div.sv
// Pipelined restoring divider for both coordinates, one quotient bit per stage.
`timescale 1ns / 1ps

module sit_div #(
    parameter int NW = 2 * (sit_pkg::COORD_BITS_DEF + 1) + 1,
    parameter int QB = sit_pkg::COORD_BITS_DEF + 1 + sit_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  sit_pkg::sit_side_t in_side,
    input  logic [NW-1:0]      in_den,
    input  logic [NW-1:0]      in_rem_x,
    input  logic [QB-1:0]      in_lo_x,
    input  logic [NW-1:0]      in_rem_y,
    input  logic [QB-1:0]      in_lo_y,
    output logic               out_valid,
    output sit_pkg::sit_side_t out_side,
    output logic [NW-1:0]      out_rem_x,
    output logic [QB-1:0]      out_quo_x,
    output logic [NW-1:0]      out_rem_y,
    output logic [QB-1:0]      out_quo_y
);
    import sit_pkg::*;

    logic [QB-1:0] vld_reg;
    sit_side_t     side_reg  [QB];
    logic [NW-1:0] den_reg   [QB];
    logic [NW-1:0] rem_x_reg [QB];
    logic [NW-1:0] rem_y_reg [QB];
    logic [QB-1:0] lo_x_reg  [QB];
    logic [QB-1:0] lo_y_reg  [QB];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[QB-2:0], in_valid};
        end
    end

    genvar k;
    generate
        for (k = 0; k < QB; k++) begin : g_step
            sit_side_t     side_prev;
            logic [NW-1:0] den_prev, rem_xp, rem_yp, sh_x, sh_y;
            logic [QB-1:0] lo_xp, lo_yp;
            logic          ge_x, ge_y;

            if (k == 0) begin : g_first
                assign side_prev = in_side;
                assign den_prev  = in_den;
                assign rem_xp    = in_rem_x;
                assign rem_yp    = in_rem_y;
                assign lo_xp     = in_lo_x;
                assign lo_yp     = in_lo_y;
            end else begin : g_next
                assign side_prev = side_reg[k-1];
                assign den_prev  = den_reg[k-1];
                assign rem_xp    = rem_x_reg[k-1];
                assign rem_yp    = rem_y_reg[k-1];
                assign lo_xp     = lo_x_reg[k-1];
                assign lo_yp     = lo_y_reg[k-1];
            end

            always_comb begin
                sh_x = {rem_xp[NW-2:0], lo_xp[QB-1]};
                sh_y = {rem_yp[NW-2:0], lo_yp[QB-1]};
                ge_x = sh_x >= den_prev;
                ge_y = sh_y >= den_prev;
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    side_reg[k]  <= side_prev;
                    den_reg[k]   <= den_prev;
                    rem_x_reg[k] <= ge_x ? sh_x - den_prev : sh_x;
                    rem_y_reg[k] <= ge_y ? sh_y - den_prev : sh_y;
                    lo_x_reg[k]  <= {lo_xp[QB-2:0], ge_x};
                    lo_y_reg[k]  <= {lo_yp[QB-2:0], ge_y};
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[QB-1];
    assign out_side  = side_reg[QB-1];
    assign out_rem_x = rem_x_reg[QB-1];
    assign out_quo_x = lo_x_reg[QB-1];
    assign out_rem_y = rem_y_reg[QB-1];
    assign out_quo_y = lo_y_reg[QB-1];

endmodule

FILE: verif/sit_checker.sv
// Checker for the segment intersection test: predicts each result and compares it.
`timescale 1ns / 1ps

module sit_checker #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic signed [COORD_BITS-1:0]      s_a_start_x,
    input  logic signed [COORD_BITS-1:0]      s_a_start_y,
    input  logic signed [COORD_BITS-1:0]      s_a_end_x,
    input  logic signed [COORD_BITS-1:0]      s_a_end_y,
    input  logic signed [COORD_BITS-1:0]      s_b_start_x,
    input  logic signed [COORD_BITS-1:0]      s_b_start_y,
    input  logic signed [COORD_BITS-1:0]      s_b_end_x,
    input  logic signed [COORD_BITS-1:0]      s_b_end_y,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic                              m_hit,
    input  logic signed [sit_pkg::OUT_W-1:0]  m_cross_x,
    input  logic signed [sit_pkg::OUT_W-1:0]  m_cross_y,
    output int                                fail_count,
    output int                                pending
);
    import sit_pkg::*;

    typedef struct packed {
        logic                    hit;
        logic signed [OUT_W-1:0] cx;
        logic signed [OUT_W-1:0] cy;
    } crossing_t;

    crossing_t crossings_due[$];

    // floor(p0*2^F + s*tn*2^F/den), exact via wide integers
    function automatic logic signed [OUT_W-1:0] place(longint p0, longint s,
                                                      longint tn, longint den);
        logic signed [127:0] num, q;
        num = (128'(signed'(s)) * tn) <<< FRAC_BITS;
        q = num / den;
        if (num % den != 0 && num < 0) q = q - 1;
        q = q + (128'(signed'(p0)) <<< FRAC_BITS);
        return q[OUT_W-1:0];
    endfunction

    function automatic crossing_t crossing_of(longint ax0, longint ay0, longint ax1,
                                              longint ay1, longint bx0, longint by0,
                                              longint bx1, longint by1);
        longint s1x, s1y, s2x, s2y, dx, dy, sn, tn, den;
        crossing_t r;
        s1x = ax1 - ax0; s1y = ay1 - ay0;
        s2x = bx1 - bx0; s2y = by1 - by0;
        dx = ax0 - bx0;  dy = ay0 - by0;
        sn = s1x * dy - s1y * dx;
        tn = s2x * dy - s2y * dx;
        den = s1x * s2y - s2x * s1y;
        if (den < 0) begin
            den = -den; sn = -sn; tn = -tn;
        end
        r = '0;
        r.hit = den != 0 && sn >= 0 && sn <= den && tn >= 0 && tn <= den;
        if (r.hit) begin
            r.cx = place(ax0, s1x, tn, den);
            r.cy = place(ay0, s1y, tn, den);
        end
        return r;
    endfunction

    assign pending = crossings_due.size();

    always @(posedge aclk) begin
        crossing_t want;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready)
                crossings_due.push_back(crossing_of(
                    longint'(s_a_start_x), longint'(s_a_start_y),
                    longint'(s_a_end_x), longint'(s_a_end_y),
                    longint'(s_b_start_x), longint'(s_b_start_y),
                    longint'(s_b_end_x), longint'(s_b_end_y)));
            if (m_valid && m_ready) begin
                if (crossings_due.size() == 0) begin
                    if (fail_count < 10) $display("checker: result with none expected");
                    fail_count <= fail_count + 1;
                end else begin
                    want = crossings_due.pop_front();
                    if (want.hit !== m_hit || want.cx !== m_cross_x
                            || want.cy !== m_cross_y) begin
                        if (fail_count < 10)
                            $display("checker: expected hit=%0d x=%0d y=%0d, got %0d %0d %0d",
                                     want.hit, want.cx, want.cy, m_hit, m_cross_x, m_cross_y);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: verif/tb.sv
// Testbench top for the segment intersection test: stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import sit_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int WATCHDOG = 20000;

    logic aclk, aresetn, s_valid, s_ready, m_valid, m_ready, m_hit;
    logic signed [CB-1:0] c [8];
    logic signed [OUT_W-1:0] m_cross_x, m_cross_y;
    int fail_count, pending, idle_cycles;
    int send_idle, recv_idle;   // idle chance in percent

    segment_intersection_test u_dut (
        .aclk, .aresetn, .s_valid, .s_ready,
        .s_a_start_x(c[0]), .s_a_start_y(c[1]), .s_a_end_x(c[2]), .s_a_end_y(c[3]),
        .s_b_start_x(c[4]), .s_b_start_y(c[5]), .s_b_end_x(c[6]), .s_b_end_y(c[7]),
        .m_valid, .m_ready, .m_hit, .m_cross_x, .m_cross_y
    );

    sit_checker u_checker (
        .aclk, .aresetn, .s_valid, .s_ready,
        .s_a_start_x(c[0]), .s_a_start_y(c[1]), .s_a_end_x(c[2]), .s_a_end_y(c[3]),
        .s_b_start_x(c[4]), .s_b_start_y(c[5]), .s_b_end_x(c[6]), .s_b_end_y(c[7]),
        .m_valid, .m_ready, .m_hit, .m_cross_x, .m_cross_y,
        .fail_count, .pending
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Stall the receiver at random, changed at the falling edge only.
    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= recv_idle);

    // Count cycles with no accepted item on either channel; bail out at the limit.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Idle at random, present one item and hold it until accepted.
    // Valid drops only when the sender idles or stops.
    task automatic send_item(input logic signed [CB-1:0] v [8]);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1;
        for (int i = 0; i < 8; i++) c[i] <= v[i];
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_pair(input int ax0, ay0, ax1, ay1, bx0, by0, bx1, by1);
        logic signed [CB-1:0] v [8];
        v = '{CB'(ax0), CB'(ay0), CB'(ax1), CB'(ay1), CB'(bx0), CB'(by0), CB'(bx1),
              CB'(by1)};
        send_item(v);
    endtask

    // Random pairs: mostly crossing segments built around a shared point,
    // the rest raw noise over the full coordinate range.
    task automatic send_random(input int n);
        logic signed [CB-1:0] v [8];
        int px, py, span;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(3) == 0) begin
                for (int i = 0; i < 8; i++) v[i] = CB'($urandom);
            end else begin
                span = $urandom_range(2) == 0 ? 16000 : $urandom_range(200);
                px = $urandom_range(2 * (32767 - span)) - (32767 - span);
                py = $urandom_range(2 * (32767 - span)) - (32767 - span);
                v[0] = CB'(px - int'($urandom_range(span)));
                v[1] = CB'(py - int'($urandom_range(span)));
                v[2] = CB'(px + int'($urandom_range(span)));
                v[3] = CB'(py + int'($urandom_range(span)));
                v[4] = CB'(px + int'($urandom_range(span)));
                v[5] = CB'(py - int'($urandom_range(span)));
                v[6] = CB'(px - int'($urandom_range(span)));
                v[7] = CB'(py + int'($urandom_range(span)));
            end
            send_item(v);
        end
    endtask

    task automatic drain();
        s_valid <= 0;
        while (pending != 0) @(negedge aclk);
    endtask

    initial begin
        aresetn = 0; s_valid = 0; m_ready = 0;
        for (int i = 0; i < 8; i++) c[i] = '0;
        send_idle = 7; recv_idle = 67;
        repeat (11) @(negedge aclk);
        aresetn = 1;

        // Directed: plain cross, shared endpoints, touching ends, parallel,
        // collinear overlap, zero-length segments, and the coordinate extremes.
        send_pair(0, 0, 10, 10, 0, 10, 10, 0);
        send_pair(0, 0, 10, 0, 10, 0, 10, 10);
        send_pair(0, 0, 3, 7, 0, 0, -5, 2);
        send_pair(0, 0, 10, 0, 5, 1, 5, 9);
        send_pair(0, 0, 10, 0, 0, 1, 10, 1);
        send_pair(0, 0, 10, 0, 2, 0, 20, 0);
        send_pair(4, 4, 4, 4, 0, 0, 9, 9);
        send_pair(3, 3, 3, 3, 3, 3, 3, 3);
        send_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        send_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
        send_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767);
        send_pair(0, 0, 3, 1, 1, 0, 0, 1);
        send_pair(0, 0, -3, -1, -1, 0, 0, -1);
        send_pair(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767);
        send_pair(32767, 32767, -32768, -32768, 0, 0, 0, 0);
        send_pair(0, 0, 1, 7, 1, 0, 0, 3);

        // Hold off until the pipeline is empty before the random items.
        drain();
        send_random(400);
        send_idle = 67; recv_idle = 7;
        send_random(400);
        send_idle = 0; recv_idle = 0;
        send_random(400);

        drain();
        repeat (40) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule

FILE: files.f
src/sit_pkg.sv
src/sit_geom.sv
src/sit_div.sv
src/segment_intersection_test.sv
verif/sit_checker.sv
verif/tb.sv
